[rtl/core/uvd_pkg.sv]
// Shared types and widths for the unit vector and derivative block.
package uvd_pkg;

  localparam int M_W = 97;  // width of the signed numerator of the derivative
  localparam int Y_W = 82;  // width of the scaled numerator magnitude

  typedef logic signed [31:0] word_t;

  // Per-item data that travels along the pipeline next to the arithmetic cells.
  typedef struct packed {
    logic              zero;
    logic [2:0]        aneg;
    logic [2:0]        mneg;
    logic [2:0]        ovf;
    logic [4:0]        k;
    logic [31:0]       r;
    logic [2:0][31:0]  x;
    word_t [2:0]       d;
    word_t [2:0]       q;
  } item_t;

  // State of one square root cell: partial remainder, partial root, radicand bits.
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] t;
  } sqrt_st_t;

  // State of one divider cell: remainder and a shared dividend and quotient register.
  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] acc;
  } div_st_t;

endpackage

[rtl/core/unit_vector_and_derivative_top.sv]
// Top level: unit vector q = A/|A| and its time derivative, fully pipelined.
//
// Usage: present A (ax, ay, az) and its derivative (adx, ady, adz), all signed
// Q16.16, on the input channel with in_valid; a request is taken when in_valid
// and in_ready are both high. One result leaves on the output channel per
// request: q in signed Q2.30, q_dot in signed Q16.16 saturated, and zero_norm,
// which is set (with all values zero) when A is the zero vector.
// Throughput is one request per cycle while the receiver does not stall, set by
// the chain of one-bit cells: 32 square root cells, 30 cells for the unit
// vector quotient and 33 for the derivative quotient, between a few multiply
// and add stages.
// When the receiver stalls, the pipeline keeps advancing until one more result
// lands in a skid register behind the output register; after that in_ready
// drops and the whole pipeline holds until the output is taken. Reset clears all
// valid flags, so no results are in flight afterwards.
module unit_vector_and_derivative_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvd_pkg::word_t     ax,
  input  uvd_pkg::word_t     ay,
  input  uvd_pkg::word_t     az,
  input  uvd_pkg::word_t     adx,
  input  uvd_pkg::word_t     ady,
  input  uvd_pkg::word_t     adz,
  output logic               out_valid,
  input  logic               out_ready,
  output uvd_pkg::word_t     qx,
  output uvd_pkg::word_t     qy,
  output uvd_pkg::word_t     qz,
  output uvd_pkg::word_t     qdx,
  output uvd_pkg::word_t     qdy,
  output uvd_pkg::word_t     qdz,
  output logic               zero_norm
);
  import uvd_pkg::*;

  localparam int SQ_CELLS = 32;
  localparam int QF_CELLS = 30;
  localparam int QD_CELLS = 33;
  localparam int NRM_STEPS = 5;
  localparam int LAT = 2 + (NRM_STEPS + 1) + 1 + SQ_CELLS + 1 + QF_CELLS + 8 + 1 + QD_CELLS;

  typedef struct packed {
    word_t [2:0] q;
    word_t [2:0] qd;
    logic        zero;
  } res_t;

  logic           adv;
  logic [LAT-1:0] vld;
  word_t [2:0]    a_in;
  word_t [2:0]    d_in;

  assign a_in = {az, ay, ax};
  assign d_in = {adz, ady, adx};

  // Skid register full means the pipeline has nowhere to put its last item.
  logic ov;
  logic sv;
  assign adv      = !sv;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid && in_ready};
    end
  end

  // Squares and magnitudes.
  logic [2:0][63:0] sq1;
  item_t            it1;
  item_t            it1_next;
  logic [63:0]      s2;
  item_t            it2;

  always_comb begin
    it1_next = '0;
    for (int i = 0; i < 3; i++) begin
      it1_next.aneg[i] = a_in[i][31];
      it1_next.x[i]    = a_in[i][31] ? 32'(-a_in[i]) : a_in[i];
      it1_next.d[i]    = d_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1 <= it1_next;
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= 64'(a_in[i]) * 64'(a_in[i]);
      end
      s2  <= sq1[0] + sq1[1] + sq1[2];
      it2 <= it1;
    end
  end

  // Normalization: shift the sum of squares left by an even count until one of
  // its top two bits is set.
  logic [63:0] t_n [0:NRM_STEPS];
  item_t       it_n [0:NRM_STEPS];
  item_t       it_n0_next;

  always_comb begin
    it_n0_next      = it2;
    it_n0_next.zero = (s2 == '0);
    it_n0_next.k    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_n[0]  <= s2;
      it_n[0] <= it_n0_next;
    end
  end

  for (genvar j = 0; j < NRM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic  hz;
    item_t it_next;
    assign hz = (t_n[j][63 -: SH] == '0);
    always_comb begin
      it_next   = it_n[j];
      it_next.k = it_n[j].k | (hz ? 5'(SH / 2) : 5'd0);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        t_n[j+1]  <= hz ? (t_n[j] << SH) : t_n[j];
        it_n[j+1] <= it_next;
      end
    end
  end

  // Square root chain.
  sqrt_st_t sq_st [0:SQ_CELLS];
  item_t    it_s [0:SQ_CELLS];
  item_t    it_s0_next;

  always_comb begin
    it_s0_next = it_n[NRM_STEPS];
    for (int i = 0; i < 3; i++) begin
      it_s0_next.x[i] = it_n[NRM_STEPS].x[i] << it_n[NRM_STEPS].k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_st[0].rem  <= '0;
      sq_st[0].root <= '0;
      sq_st[0].t    <= t_n[NRM_STEPS];
      it_s[0]       <= it_s0_next;
    end
  end

  for (genvar c = 0; c < SQ_CELLS; c++) begin : g_sqrt
    uvd_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .din  (sq_st[c]),
      .dout (sq_st[c+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        it_s[c+1] <= it_s[c];
      end
    end
  end

  // Unit vector quotient: the scaled magnitude never exceeds the root, so the
  // integer part is a single bit followed by the fraction bits.
  div_st_t qdiv [3][0:QF_CELLS];
  item_t   it_q [0:QF_CELLS];
  logic [31:0] r_s;
  item_t   it_q0_next;
  assign r_s = sq_st[SQ_CELLS].root;

  always_comb begin
    it_q0_next   = it_s[SQ_CELLS];
    it_q0_next.r = r_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_q[0] <= it_q0_next;
      for (int i = 0; i < 3; i++) begin
        qdiv[i][0].rem <= (it_s[SQ_CELLS].x[i] >= r_s) ? 32'(it_s[SQ_CELLS].x[i] - r_s)
                                                       : it_s[SQ_CELLS].x[i];
        qdiv[i][0].acc <= {32'd0, it_s[SQ_CELLS].x[i] >= r_s};
      end
    end
  end

  for (genvar c = 0; c < QF_CELLS; c++) begin : g_qdiv
    for (genvar i = 0; i < 3; i++) begin : g_lane
      uvd_div_cell u_cell (
        .clk     (clk),
        .en      (adv),
        .divisor (it_q[c].r),
        .din     (qdiv[i][c]),
        .dout    (qdiv[i][c+1])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        it_q[c+1] <= it_q[c];
      end
    end
  end

  // Dot product, the correction term and the signed numerator of q_dot.
  item_t                    it_p1, it_p2, it_p3, it_p4, it_p5, it_p6, it_p7, it_p8;
  item_t                    it_p1_next, it_p7_next;
  logic signed [2:0][63:0]  prod;
  logic signed [63:0]       p;
  logic signed [2:0][63:0]  pp_hi;
  logic signed [2:0][64:0]  pp_lo;
  logic signed [M_W-1:0]    qp [3];
  logic signed [M_W-1:0]    m [3];
  logic [M_W-2:0]           mmag [3];
  logic [Y_W-1:0]           y [3];
  logic [5:0]               sh;

  assign sh = 6'd44 - {1'b0, it_p7.k};

  always_comb begin
    it_p1_next = it_q[QF_CELLS];
    for (int i = 0; i < 3; i++) begin
      it_p1_next.q[i] = it_q[QF_CELLS].aneg[i] ? 32'(-{1'b0, qdiv[i][QF_CELLS].acc[30:0]})
                                               : {1'b0, qdiv[i][QF_CELLS].acc[30:0]};
    end
  end

  always_comb begin
    it_p7_next = it_p6;
    for (int i = 0; i < 3; i++) begin
      it_p7_next.mneg[i] = m[i][M_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_p1 <= it_p1_next;

      it_p2 <= it_p1;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= 64'($signed(it_p1.q[i])) * 64'($signed(it_p1.d[i]));
      end

      it_p3 <= it_p2;
      p     <= $signed(prod[0]) + $signed(prod[1]) + $signed(prod[2]);

      // The 64-bit dot product is split in halves to keep each multiplier narrow.
      it_p4 <= it_p3;
      for (int i = 0; i < 3; i++) begin
        pp_hi[i] <= 64'($signed(it_p3.q[i])) * 64'($signed(p[63:32]));
        pp_lo[i] <= 65'($signed(it_p3.q[i])) * 65'($signed({1'b0, p[31:0]}));
      end

      it_p5 <= it_p4;
      for (int i = 0; i < 3; i++) begin
        qp[i] <= (M_W'($signed(pp_hi[i])) <<< 32) + M_W'($signed(pp_lo[i]));
      end

      it_p6 <= it_p5;
      for (int i = 0; i < 3; i++) begin
        m[i] <= (M_W'($signed(it_p5.d[i])) <<< 60) - qp[i];
      end

      it_p7 <= it_p7_next;
      for (int i = 0; i < 3; i++) begin
        mmag[i] <= m[i][M_W-1] ? (M_W-1)'(-m[i]) : m[i][M_W-2:0];
      end

      it_p8 <= it_p7;
      for (int i = 0; i < 3; i++) begin
        y[i] <= Y_W'(mmag[i] >> sh);
      end
    end
  end

  // Derivative quotient: a quotient at or above 2^33 only needs to be flagged.
  div_st_t ddiv [3][0:QD_CELLS];
  item_t   it_d [0:QD_CELLS];
  item_t   it_d0_next;

  always_comb begin
    it_d0_next = it_p8;
    for (int i = 0; i < 3; i++) begin
      it_d0_next.ovf[i] = (y[i][Y_W-1:QD_CELLS] >= {{(Y_W - QD_CELLS - 32){1'b0}}, it_p8.r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_d[0] <= it_d0_next;
      for (int i = 0; i < 3; i++) begin
        ddiv[i][0].rem <= it_d0_next.ovf[i] ? '0 : y[i][QD_CELLS+31:QD_CELLS];
        ddiv[i][0].acc <= y[i][QD_CELLS-1:0];
      end
    end
  end

  for (genvar c = 0; c < QD_CELLS; c++) begin : g_ddiv
    for (genvar i = 0; i < 3; i++) begin : g_lane
      uvd_div_cell u_cell (
        .clk     (clk),
        .en      (adv),
        .divisor (it_d[c].r),
        .din     (ddiv[i][c]),
        .dout    (ddiv[i][c+1])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        it_d[c+1] <= it_d[c];
      end
    end
  end

  // Sign, saturation and the zero-vector override.
  res_t pres;

  always_comb begin
    logic [32:0] z;
    pres.zero = it_d[QD_CELLS].zero;
    for (int i = 0; i < 3; i++) begin
      z = ddiv[i][QD_CELLS].acc;
      pres.q[i] = it_d[QD_CELLS].zero ? '0 : it_d[QD_CELLS].q[i];
      if (it_d[QD_CELLS].zero) begin
        pres.qd[i] = '0;
      end else if (it_d[QD_CELLS].mneg[i]) begin
        if (it_d[QD_CELLS].ovf[i] || z > 33'h0_8000_0000) begin
          pres.qd[i] = 32'h8000_0000;
        end else begin
          pres.qd[i] = 32'(-z[31:0]);
        end
      end else begin
        if (it_d[QD_CELLS].ovf[i] || z[32] || z[31]) begin
          pres.qd[i] = 32'h7FFF_FFFF;
        end else begin
          pres.qd[i] = z[31:0];
        end
      end
    end
  end

  // Output register with a skid register behind it.
  res_t od;
  res_t sd;
  logic pv;
  assign pv = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || out_ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= pv;
      end
    end else if (pv && adv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || out_ready) begin
      if (sv) begin
        od <= sd;
      end else if (pv) begin
        od <= pres;
      end
    end else if (pv && adv) begin
      sd <= pres;
    end
  end

  assign out_valid = ov;
  assign qx        = od.q[0];
  assign qy        = od.q[1];
  assign qz        = od.q[2];
  assign qdx       = od.qd[0];
  assign qdy       = od.qd[1];
  assign qdz       = od.qd[2];
  assign zero_norm = od.zero;

endmodule

[rtl/core/uvd_sqrt_cell.sv]
// One bit step of the pipelined integer square root.
module uvd_sqrt_cell (
  input  logic              clk,
  input  logic              en,
  input  uvd_pkg::sqrt_st_t din,
  output uvd_pkg::sqrt_st_t dout
);
  import uvd_pkg::*;

  logic [35:0] trem;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    trem  = {din.rem, din.t[63:62]};
    trial = {2'b00, din.root, 2'b01};
    ge    = (trem >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= ge ? 34'(trem - trial) : trem[33:0];
      dout.root <= {din.root[30:0], ge};
      dout.t    <= {din.t[61:0], 2'b00};
    end
  end

endmodule

[rtl/core/uvd_div_cell.sv]
// One quotient bit step of a pipelined restoring divider by a 32-bit divisor.
module uvd_div_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      divisor,
  input  uvd_pkg::div_st_t din,
  output uvd_pkg::div_st_t dout
);
  import uvd_pkg::*;

  logic [32:0] trem;
  logic [32:0] dv;
  logic        ge;

  always_comb begin
    trem = {din.rem, din.acc[32]};
    dv   = {1'b0, divisor};
    ge   = (trem >= dv);
  end

  // The dividend bits leave the top of acc while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? 32'(trem - dv) : trem[31:0];
      dout.acc <= {din.acc[31:0], ge};
    end
  end

endmodule

[rtl/core/uvd_checker.sv]
// Port-level checks for the unit vector and derivative block, bound to the top level.
module uvd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input uvd_pkg::word_t ax,
  input uvd_pkg::word_t ay,
  input uvd_pkg::word_t az,
  input uvd_pkg::word_t adx,
  input uvd_pkg::word_t ady,
  input uvd_pkg::word_t adz,
  input logic           out_valid,
  input logic           out_ready,
  input uvd_pkg::word_t qx,
  input uvd_pkg::word_t qy,
  input uvd_pkg::word_t qz,
  input uvd_pkg::word_t qdx,
  input uvd_pkg::word_t qdy,
  input uvd_pkg::word_t qdz,
  input logic           zero_norm
);
  import uvd_pkg::*;

  // A waiting input request stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(ax) && $stable(ay) && $stable(az) &&
                              $stable(adx) && $stable(ady) && $stable(adz))
    else $error("input request changed while waiting");

  // A stalled result stays put (checked on qx, qdx and zero_norm).
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(qx) && $stable(qdx) && $stable(zero_norm))
    else $error("output request changed while stalled");

  // With the output empty, the skid register is empty too, so requests are taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // A zero vector gives all-zero values.
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> qx == 0 && qy == 0 && qz == 0 &&
                               qdx == 0 && qdy == 0 && qdz == 0)
    else $error("zero vector gave nonzero values");

  // Unit vector components never exceed one in magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> qx >= -32'sh4000_0000 && qx <= 32'sh4000_0000 &&
                  qy >= -32'sh4000_0000 && qy <= 32'sh4000_0000 &&
                  qz >= -32'sh4000_0000 && qz <= 32'sh4000_0000)
    else $error("unit vector component out of range");

endmodule

bind unit_vector_and_derivative_top uvd_checker u_uvd_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the unit vector and derivative block.
`timescale 1ns / 100ps

class uvd_scoreboard;
  typedef struct {
    logic [31:0] q [3];
    logic [31:0] qd [3];
    logic        zero;
  } uvd_result_t;

  uvd_result_t pending[$];
  int errors = 0;
  int checked = 0;
  int zero_seen = 0;
  int sat_seen = 0;

  // Clamp a sign and magnitude to the signed 32-bit range.
  function automatic logic [31:0] clamp32(bit neg, logic [127:0] mag);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'(0 - mag[31:0]);
    end
    if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Work out the result of one accepted request and queue it.
  function void note_request(logic [31:0] a [3], logic [31:0] d [3]);
    uvd_result_t e;
    logic signed [127:0] sa [3];
    logic signed [127:0] sd [3];
    logic signed [127:0] sq [3];
    logic signed [127:0] dot;
    logic signed [127:0] m;
    logic [127:0] mag;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] r;
    int k;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      sa[i] = $signed(a[i]);
      sd[i] = $signed(d[i]);
      sum = sum + 64'(sa[i] * sa[i]);
    end
    e.zero = (sum == 0);
    for (int i = 0; i < 3; i++) begin
      e.q[i] = 0;
      e.qd[i] = 0;
    end
    if (!e.zero) begin
      t = sum;
      k = 0;
      while (t[63:62] == 2'b00) begin
        t = t << 2;
        k++;
      end
      r = root64(t);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        mag = sa[i] < 0 ? 128'(-sa[i]) : 128'(sa[i]);
        e.q[i] = clamp32(sa[i] < 0, (mag << (30 + k)) / 128'(r));
        sq[i] = $signed(e.q[i]);
        dot = dot + sq[i] * sd[i];
      end
      for (int i = 0; i < 3; i++) begin
        m = (sd[i] <<< 60) - sq[i] * dot;
        mag = m < 0 ? 128'(-m) : 128'(m);
        mag = (mag / 128'(r)) >> (44 - k);
        e.qd[i] = clamp32(m < 0, mag);
        if (mag > 128'h7FFF_FFFF) sat_seen++;
      end
    end else begin
      zero_seen++;
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic [31:0] q [3], logic [31:0] qd [3], logic zero);
    uvd_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: result arrived with no request outstanding", $realtime);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    for (int i = 0; i < 3; i++) begin
      if (q[i] !== e.q[i]) begin
        $display("%0t: q[%0d] expected %h actual %h", $realtime, i, e.q[i], q[i]);
        errors++;
      end
      if (qd[i] !== e.qd[i]) begin
        $display("%0t: qd[%0d] expected %h actual %h", $realtime, i, e.qd[i], qd[i]);
        errors++;
      end
    end
    if (zero !== e.zero) begin
      $display("%0t: zero_norm expected %b actual %b", $realtime, e.zero, zero);
      errors++;
    end
  endfunction
endclass

module tb;
  import uvd_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  word_t ax, ay, az, adx, ady, adz;
  word_t qx, qy, qz, qdx, qdy, qdz;
  logic zero_norm;

  uvd_scoreboard sb;
  bit calm;
  int stall_cycles;

  unit_vector_and_derivative_top dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Random field value: sometimes full range, often scaled down so all lengths occur.
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: return v;
      1: return 32'($signed(v) >>> $urandom_range(1, 31));
      2: return 32'($signed(v) >>> $urandom_range(12, 20));
      default: return 32'($signed(v) >>> 24);
    endcase
  endfunction

  task automatic send_request(logic [31:0] a [3], logic [31:0] d [3]);
    if (!calm) begin
      while ($urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    ax <= a[0]; ay <= a[1]; az <= a[2];
    adx <= d[0]; ady <= d[1]; adz <= d[2];
    do @(posedge clk); while (!in_ready);
    sb.note_request(a, d);
  endtask

  task automatic send_vec(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                          logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    logic [31:0] a [3];
    logic [31:0] d [3];
    a[0] = a0; a[1] = a1; a[2] = a2;
    d[0] = d0; d[1] = d1; d[2] = d2;
    send_request(a, d);
  endtask

  // Receiver side: random stalls except while the calm window is open.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    logic [31:0] q [3];
    logic [31:0] qd [3];
    if (!rst && out_valid && out_ready) begin
      q[0] = qx; q[1] = qy; q[2] = qz;
      qd[0] = qdx; qd[1] = qdy; qd[2] = qdz;
      sb.check_result(q, qd, zero_norm);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] a [3];
    logic [31:0] d [3];
    sb = new();
    calm = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    ax = 0; ay = 0; az = 0; adx = 0; ady = 0; adz = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero vector, with and without a derivative.
    send_vec(0, 0, 0, 0, 0, 0);
    send_vec(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    // Extremes of the vector.
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2, 3);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    send_vec(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0);
    send_vec(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Tiny vectors, where the derivative blows up and saturates, then vectors with components of one.
    send_vec(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vec(0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_vec(1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec(32'h0001_0000, 0, 0, 32'h0100_0000, 32'h0100_0000, 0);
    send_vec(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 0);
    // Derivative parallel to the vector gives a zero unit derivative, followed by a large mixed-sign vector.
    send_vec(32'h0003_0000, 32'h0004_0000, 0, 32'h0006_0000, 32'h0008_0000, 0);
    send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    for (int n = 0; n < 540; n++) begin
      calm = (n >= 200 && n < 320);
      for (int i = 0; i < 3; i++) begin
        a[i] = pick_word();
        d[i] = pick_word();
      end
      if ($urandom_range(0, 39) == 0) begin
        a[0] = 0; a[1] = 0; a[2] = 0;
      end
      send_request(a, d);
    end
    calm = 0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Checked %0d results: %0d zero-length vectors, %0d saturated derivatives.",
             sb.checked, sb.zero_seen, sb.sat_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
